@@ rtl/pointer_accel_position_tracker_defines.svh @@
// assertion macros for the pointer position tracker
// no dependencies; included by files that carry concurrent checks
`ifndef POINTER_ACCEL_POSITION_TRACKER_DEFINES_SVH
`define POINTER_ACCEL_POSITION_TRACKER_DEFINES_SVH

// same-cycle implication, checks off while reset is low
`define PAT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pointer tracker check failed");

// next-cycle implication, checks off while reset is low
`define PAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pointer tracker check failed");

`endif

@@ rtl/pat_pkg.sv @@
// shared types and codes for the pointer position tracker
// no dependencies; used by pat_axis and pointer_accel_position_tracker
`timescale 1ns / 1ps

package pat_pkg;

    localparam int THRESH_BITS  = 15;
    localparam int SCALE_BITS   = 8;
    localparam int OP_BITS      = 3;
    localparam int STATUS_BITS  = 2;
    localparam int CFG_IDX_BITS = 3;

    typedef enum logic [OP_BITS-1:0] {
        OP_NONE    = 3'd0,
        OP_REL     = 3'd1,
        OP_ABS     = 3'd2,
        OP_BUTTONS = 3'd3,
        OP_ERROR   = 3'd4,
        OP_MOVE_TO = 3'd5,
        OP_RECLAMP = 3'd6
    } t_op;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_NONE    = 2'd0,
        ST_CHANGED = 2'd1,
        ST_ERROR   = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_MIN_X       = 3'd0,
        CFG_MIN_Y       = 3'd1,
        CFG_MAX_X       = 3'd2,
        CFG_MAX_Y       = 3'd3,
        CFG_THRESHOLD   = 3'd4,
        CFG_ACCEL_SCALE = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [THRESH_BITS-1:0] threshold;
        logic [SCALE_BITS-1:0]  scale;
    } t_accel_cfg;

endpackage

@@ rtl/pat_axis.sv @@
// one axis of the position update: acceleration, add and clamp
// depends on pat_pkg (acceleration settings struct, widths)
`timescale 1ns / 1ps

module pat_axis #(
    parameter int COORD_BITS = 16
) (
    input  pat_pkg::t_accel_cfg    i_accel,
    input  logic                   i_rel,
    input  logic [COORD_BITS-1:0]  i_cur,
    input  logic [COORD_BITS-1:0]  i_move,
    input  logic [COORD_BITS-1:0]  i_min,
    input  logic [COORD_BITS-1:0]  i_max,
    output logic [COORD_BITS-1:0]  o_next
);

    localparam int TB = pat_pkg::THRESH_BITS;
    localparam int SB = pat_pkg::SCALE_BITS;
    localparam int CW = (COORD_BITS > TB) ? COORD_BITS : TB;
    localparam int PW = COORD_BITS + SB;
    localparam int AW = ((PW > TB) ? PW : TB) + 1;
    localparam int SW = AW + 2;

    logic                  w_neg;
    logic [COORD_BITS-1:0] w_mag;
    logic [CW-1:0]         w_mag_ext;
    logic [CW-1:0]         w_thr_ext;
    logic                  w_above;
    logic [CW-1:0]         w_excess;
    logic [PW-1:0]         w_prod;
    logic [AW-1:0]         w_acc_mag;
    logic signed [AW:0]    w_acc;
    logic signed [SW-1:0]  w_cur_ext;
    logic signed [SW-1:0]  w_move_ext;
    logic signed [SW-1:0]  w_min_ext;
    logic signed [SW-1:0]  w_max_ext;
    logic signed [SW-1:0]  w_target;
    logic signed [SW-1:0]  w_lo_clamped;
    logic signed [SW-1:0]  w_clamped;

    always_comb begin
        w_neg     = i_move[COORD_BITS-1];
        // magnitude of the most negative value still fits as unsigned
        w_mag     = w_neg ? (~i_move + 1'b1) : i_move;
        w_mag_ext = CW'(w_mag);
        w_thr_ext = CW'(i_accel.threshold);
        w_above   = w_mag_ext > w_thr_ext;
        w_excess  = w_mag_ext - w_thr_ext;
        w_prod    = PW'(w_excess[COORD_BITS-1:0]) * PW'(i_accel.scale);
        w_acc_mag = w_above ? (AW'(i_accel.threshold) + AW'(w_prod)) : AW'(w_mag);
        w_acc     = w_neg ? -$signed({1'b0, w_acc_mag}) : $signed({1'b0, w_acc_mag});

        w_cur_ext  = {{(SW-COORD_BITS){i_cur[COORD_BITS-1]}}, i_cur};
        w_move_ext = {{(SW-COORD_BITS){i_move[COORD_BITS-1]}}, i_move};
        w_min_ext  = {{(SW-COORD_BITS){i_min[COORD_BITS-1]}}, i_min};
        w_max_ext  = {{(SW-COORD_BITS){i_max[COORD_BITS-1]}}, i_max};

        w_target = i_rel ? (w_cur_ext + {w_acc[AW], w_acc}) : w_move_ext;

        // low bound first, then high bound, so max wins when min > max
        w_lo_clamped = (w_target < w_min_ext) ? w_min_ext : w_target;
        w_clamped    = (w_lo_clamped > w_max_ext) ? w_max_ext : w_lo_clamped;
        o_next       = w_clamped[COORD_BITS-1:0];
    end

endmodule

@@ rtl/pointer_accel_position_tracker.sv @@
// pointer position tracker top level: stream ports, config registers, state
// depends on pat_pkg, pat_axis and pointer_accel_position_tracker_defines.svh
`timescale 1ns / 1ps

// Each item on the slave stream is one poll or command and yields exactly one
// result item on the master stream, in order. The block takes one item per
// clock cycle while the master side takes results. An accepted item waits in
// the input register until the result register is free; then its result is
// registered and on the master stream. The rate is set by the position update
// loop: the accelerated move, add and clamp of one item are combinational and
// go straight back into the position registers, so the next item sees them.
// While a result waits on the master side, the input register can still take
// one more item. After that the slave side stalls until the result is taken.
// Configuration writes are accepted every cycle and should only be issued
// while no item is in flight.

`include "pointer_accel_position_tracker_defines.svh"

module pointer_accel_position_tracker #(
    parameter int COORD_BITS  = 16,
    parameter int BUTTON_BITS = 3,
    localparam int CFG_BITS   = (COORD_BITS > pat_pkg::THRESH_BITS) ?
                                COORD_BITS : pat_pkg::THRESH_BITS,
    localparam int IN_BITS    = ((2*COORD_BITS + BUTTON_BITS + 7) / 8) * 8,
    localparam int OUT_BITS   = ((2*COORD_BITS + BUTTON_BITS + 1 + 7) / 8) * 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pat_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_BITS-1:0]               i_cfg_data,

    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // move_x, move_y, new_buttons, zero pad
    input  logic [IN_BITS-1:0]                i_s_axis_tdata,
    // op
    input  logic [pat_pkg::OP_BITS-1:0]       i_s_axis_tuser,

    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // report_x, report_y, report_buttons, report_taken, zero pad
    output logic [OUT_BITS-1:0]               o_m_axis_tdata,
    // status
    output logic [pat_pkg::STATUS_BITS-1:0]   o_m_axis_tuser
);

    localparam int CB = COORD_BITS;
    localparam int BB = BUTTON_BITS;

    // configuration registers
    logic [CB-1:0]        r_min_x, r_min_y, r_max_x, r_max_y;
    pat_pkg::t_accel_cfg  r_accel;

    // input register
    logic                 r_in_valid;
    pat_pkg::t_op         r_in_op;
    logic [CB-1:0]        r_in_move_x, r_in_move_y;
    logic [BB-1:0]        r_in_buttons;

    // tracked state
    logic [CB-1:0]        r_cur_x, r_cur_y;
    logic [BB-1:0]        r_cur_buttons;
    logic                 r_pending;

    // result register
    logic                 r_out_valid;
    pat_pkg::t_status     r_out_status;
    logic                 r_out_taken;

    logic [CB-1:0]        n_cur_x, n_cur_y;
    logic [BB-1:0]        n_cur_buttons;
    logic                 n_pending;
    pat_pkg::t_status     n_status;
    logic                 n_taken;

    logic                 w_adv;
    logic                 w_fire;
    logic                 w_is_cmd;
    logic                 w_rel;
    logic [CB-1:0]        w_axis_move_x, w_axis_move_y;
    logic [CB-1:0]        w_next_x, w_next_y;
    logic                 w_pos_chg;
    logic                 w_btn_chg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x         <= {1'b1, {(CB-1){1'b0}}};
            r_min_y         <= {1'b1, {(CB-1){1'b0}}};
            r_max_x         <= {1'b0, {(CB-1){1'b1}}};
            r_max_y         <= {1'b0, {(CB-1){1'b1}}};
            r_accel.threshold <= pat_pkg::THRESH_BITS'(5);
            r_accel.scale     <= pat_pkg::SCALE_BITS'(3);
        end else if (i_cfg_valid) begin
            case (pat_pkg::t_cfg_idx'(i_cfg_index))
                pat_pkg::CFG_MIN_X:       r_min_x <= i_cfg_data[CB-1:0];
                pat_pkg::CFG_MIN_Y:       r_min_y <= i_cfg_data[CB-1:0];
                pat_pkg::CFG_MAX_X:       r_max_x <= i_cfg_data[CB-1:0];
                pat_pkg::CFG_MAX_Y:       r_max_y <= i_cfg_data[CB-1:0];
                pat_pkg::CFG_THRESHOLD: begin
                    r_accel.threshold <= i_cfg_data[pat_pkg::THRESH_BITS-1:0];
                end
                pat_pkg::CFG_ACCEL_SCALE: begin
                    r_accel.scale <= i_cfg_data[pat_pkg::SCALE_BITS-1:0];
                end
                default: ;
            endcase
        end
    end

    // stream flow: the result register frees up when empty or taken
    assign w_adv           = !r_out_valid || i_m_axis_tready;
    assign w_fire          = r_in_valid && w_adv;
    assign o_s_axis_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_op      <= pat_pkg::t_op'(i_s_axis_tuser);
            r_in_move_x  <= i_s_axis_tdata[CB-1:0];
            r_in_move_y  <= i_s_axis_tdata[2*CB-1:CB];
            r_in_buttons <= i_s_axis_tdata[2*CB+BB-1:2*CB];
        end
    end

    assign w_is_cmd      = r_in_op inside {pat_pkg::OP_MOVE_TO, pat_pkg::OP_RECLAMP};
    assign w_rel         = (r_in_op == pat_pkg::OP_REL);
    // a reclamp is an absolute move to where the pointer already is
    assign w_axis_move_x = (r_in_op == pat_pkg::OP_RECLAMP) ? r_cur_x : r_in_move_x;
    assign w_axis_move_y = (r_in_op == pat_pkg::OP_RECLAMP) ? r_cur_y : r_in_move_y;

    pat_axis #(
        .COORD_BITS (CB)
    ) u_axis_x (
        .i_accel (r_accel),
        .i_rel   (w_rel),
        .i_cur   (r_cur_x),
        .i_move  (w_axis_move_x),
        .i_min   (r_min_x),
        .i_max   (r_max_x),
        .o_next  (w_next_x)
    );

    pat_axis #(
        .COORD_BITS (CB)
    ) u_axis_y (
        .i_accel (r_accel),
        .i_rel   (w_rel),
        .i_cur   (r_cur_y),
        .i_move  (w_axis_move_y),
        .i_min   (r_min_y),
        .i_max   (r_max_y),
        .o_next  (w_next_y)
    );

    assign w_pos_chg = (w_next_x != r_cur_x) || (w_next_y != r_cur_y);
    assign w_btn_chg = (r_in_buttons != r_cur_buttons);

    always_comb begin
        n_cur_x       = r_cur_x;
        n_cur_y       = r_cur_y;
        n_cur_buttons = r_cur_buttons;
        n_pending     = r_pending;
        n_status      = pat_pkg::ST_NONE;
        n_taken       = 1'b1;

        if (w_is_cmd) begin
            // commands apply even with a change pending; the next poll reports it
            if (w_pos_chg) begin
                n_cur_x   = w_next_x;
                n_cur_y   = w_next_y;
                n_pending = 1'b1;
            end
        end else if (r_pending) begin
            // report the old change, driver must resend this item
            n_pending = 1'b0;
            n_status  = pat_pkg::ST_CHANGED;
            n_taken   = 1'b0;
        end else begin
            case (r_in_op)
                pat_pkg::OP_ERROR: begin
                    n_status = pat_pkg::ST_ERROR;
                end
                pat_pkg::OP_REL, pat_pkg::OP_ABS: begin
                    n_cur_buttons = r_in_buttons;
                    n_cur_x       = w_next_x;
                    n_cur_y       = w_next_y;
                    if (w_btn_chg || w_pos_chg) begin
                        n_status = pat_pkg::ST_CHANGED;
                    end
                end
                pat_pkg::OP_BUTTONS: begin
                    n_cur_buttons = r_in_buttons;
                    if (w_btn_chg) begin
                        n_status = pat_pkg::ST_CHANGED;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x       <= '0;
            r_cur_y       <= '0;
            r_cur_buttons <= '0;
            r_pending     <= 1'b1;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
            if (w_fire) begin
                r_cur_x       <= n_cur_x;
                r_cur_y       <= n_cur_y;
                r_cur_buttons <= n_cur_buttons;
                r_pending     <= n_pending;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_status <= n_status;
            r_out_taken  <= n_taken;
        end
    end

    // position and buttons in the result are the tracked state after the item
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_BITS'({r_out_taken, r_cur_buttons, r_cur_y, r_cur_x});
    assign o_m_axis_tuser  = r_out_status;

    `PAT_ASSERT_NOW(a_untaken_is_change, i_clk, i_rst_n,
        r_out_valid && !r_out_taken, r_out_status == pat_pkg::ST_CHANGED)
    `PAT_ASSERT_NEXT(a_poll_clears_pending, i_clk, i_rst_n,
        w_fire && !w_is_cmd, !r_pending)
    `PAT_ASSERT_NEXT(a_cmd_always_taken, i_clk, i_rst_n,
        w_fire && w_is_cmd, r_out_taken && r_out_status == pat_pkg::ST_NONE)

endmodule
